/* design/pxd_pkg.sv */
`default_nettype none
package pxd_pkg;

    localparam int OUT_WORD_BITS = 32;
    localparam int PIX_PER_ITEM  = 8;
    localparam int CHUNK_BITS    = 2 * OUT_WORD_BITS;
    localparam int FILL_W        = 5;
    localparam int TOTAL_W       = 7;
    localparam int Q_DEPTH       = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH_LOG2     = 2'd0;
    localparam logic [1:0] CFG_GREY_MODE      = 2'd1;
    localparam logic [1:0] CFG_PALETTE_SELECT = 2'd2;

    // 4x4 Bayer thresholds, [row][column mod 4]
    localparam logic [3:0] BAYER4 [4][4] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    // level tables, [palette][colour]; palette three repeats palette zero
    localparam logic [4:0] LEVELS [4][4] = '{
        '{5'd0, 5'd16, 5'd11, 5'd5},
        '{5'd0, 5'd5,  5'd11, 5'd16},
        '{5'd0, 5'd16, 5'd16, 5'd16},
        '{5'd0, 5'd16, 5'd11, 5'd5}
    };

    typedef struct packed {
        logic [1:0] width_log2;
        logic       grey_mode;
        logic [1:0] palette_select;
    } t_cfg;

    // results of one item: one or two words, last word ends the run
    typedef struct packed {
        logic [OUT_WORD_BITS-1:0] word0;
        logic [OUT_WORD_BITS-1:0] word1;
        logic                     two;
    } t_job;

endpackage
`default_nettype wire

/* design/pixel_expand_dither.sv */
`default_nettype none
// pixel_expand_dither: widens guest display pixels into packed 1bpp words.
// Input channel (i_in_valid / o_in_ready): one item holds bits 31..24 of two
// plane words, a Bayer row and a row-end flag. Output channel (o_out_valid /
// i_out_ready): packed 32-bit words, leftmost pixel in bit 0, with
// o_last_of_run set on the final word an item produces.
// Config: write i_cfg_data to register i_cfg_index when i_cfg_we is high;
// 0 width_log2, 1 grey_mode, 2 palette_select. Any write drops pending bits.
// Path: the front packs each item's words into a 2-entry queue, and the
// output register takes them from the queue head.
// Throughput: one item per cycle while each item makes at most one word and
// i_out_ready stays high; at 8 output bits per pixel an item makes two words,
// and the output register, issuing one word per cycle, sets the rate.
// Stall: when i_out_ready is low the output word holds, the queue fills and
// o_in_ready drops once both queue entries are taken.
// Reset (i_rst_n low, synchronous): config to zero, accumulator empty,
// queue empty, no output valid.
module pixel_expand_dither (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_plane0_word,
    input  wire logic [31:0] i_plane1_word,
    input  wire logic [1:0]  i_dither_row,
    input  wire logic        i_row_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_out_word,
    output logic             o_last_of_run
);

    pxd_pkg::t_cfg r_cfg;
    pxd_pkg::t_job push_job, head_job;
    logic          push, q_not_full, q_not_empty, pop;

    // config registers; an unknown index writes nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pxd_pkg::CFG_WIDTH_LOG2:     r_cfg.width_log2     <= i_cfg_data;
                pxd_pkg::CFG_GREY_MODE:      r_cfg.grey_mode      <= i_cfg_data[0];
                pxd_pkg::CFG_PALETTE_SELECT: r_cfg.palette_select <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: expand, pack, and hand each item's words to the queue
    pxd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_clear       (i_cfg_we),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_plane0_word (i_plane0_word),
        .i_plane1_word (i_plane1_word),
        .i_dither_row  (i_dither_row),
        .i_row_last    (i_row_last),
        .o_job_valid   (push),
        .o_job         (push_job),
        .i_job_ready   (q_not_full)
    );

    pxd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_job  (push_job),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .o_head      (head_job),
        .i_pop       (pop)
    );

    // back: one word per cycle into the output register while the output is not stalled
    pxd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_not_empty),
        .i_job         (head_job),
        .o_job_pop     (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire

/* design/pxd_front.sv */
`default_nettype none
module pxd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pxd_pkg::t_cfg   i_cfg,
    input  wire logic            i_clear,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [31:0]     i_plane0_word,
    input  wire logic [31:0]     i_plane1_word,
    input  wire logic [1:0]      i_dither_row,
    input  wire logic            i_row_last,
    output logic                 o_job_valid,
    output pxd_pkg::t_job        o_job,
    input  wire logic            i_job_ready
);

    logic [pxd_pkg::OUT_WORD_BITS-1:0] r_acc, n_acc;
    logic [pxd_pkg::FILL_W-1:0]        r_fill, n_fill;

    logic [7:0]                        b0;
    logic [4:0]                        lvl [pxd_pkg::PIX_PER_ITEM];
    logic [pxd_pkg::CHUNK_BITS-1:0]    chunk;
    logic [pxd_pkg::CHUNK_BITS-1:0]    lo;
    logic [5:0]                        xb;
    logic [5:0]                        pix;
    logic [3:0]                        thr;
    logic [pxd_pkg::TOTAL_W-1:0]       nbits;
    logic [pxd_pkg::TOTAL_W-1:0]       total;
    logic [pxd_pkg::FILL_W-1:0]        remain;
    logic                              full1, full2, flush, accept;

    assign o_in_ready = i_job_ready;
    assign accept     = i_in_valid && o_in_ready;

    // expand the eight pixels into up to 64 output bits
    always_comb begin
        for (int i = 0; i < pxd_pkg::PIX_PER_ITEM; i++) begin
            b0[i]  = i_plane0_word[31-i];
            lvl[i] = pxd_pkg::LEVELS[i_cfg.palette_select]
                                    [{i_plane1_word[31-i], i_plane0_word[31-i]}];
        end
        chunk = '0;
        xb    = '0;
        pix   = '0;
        thr   = '0;
        for (int x = 0; x < pxd_pkg::CHUNK_BITS; x++) begin
            xb  = 6'(x);
            pix = xb >> i_cfg.width_log2;
            thr = pxd_pkg::BAYER4[i_dither_row][xb[1:0]];
            if (pix < 6'(pxd_pkg::PIX_PER_ITEM)) begin
                chunk[x] = i_cfg.grey_mode ? (lvl[pix[2:0]] > {1'b0, thr})
                                           : b0[pix[2:0]];
            end
        end
    end

    // pack against pending bits; fill stays a multiple of the item's bit count,
    // so total never exceeds 64
    always_comb begin
        nbits  = 7'(pxd_pkg::PIX_PER_ITEM) << i_cfg.width_log2;
        lo     = {{pxd_pkg::OUT_WORD_BITS{1'b0}}, r_acc} | (chunk << r_fill);
        total  = {2'b00, r_fill} + nbits;
        full2  = total[6];
        full1  = total[5];
        remain = total[4:0];
        flush  = i_row_last && (remain != '0);

        o_job.word0 = lo[31:0];
        o_job.word1 = lo[63:32];
        o_job.two   = full2 || (full1 && flush);
        o_job_valid = accept && (full2 || full1 || flush);

        n_acc  = r_acc;
        n_fill = r_fill;
        if (i_clear) begin
            n_acc  = '0;
            n_fill = '0;
        end else if (accept) begin
            if (i_row_last || remain == '0) begin
                n_acc  = '0;
                n_fill = '0;
            end else begin
                n_acc  = full1 ? lo[63:32] : lo[31:0];
                n_fill = remain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= '0;
        end else begin
            r_acc  <= n_acc;
            r_fill <= n_fill;
        end
    end

endmodule
`default_nettype wire

/* design/pxd_queue.sv */
`default_nettype none
module pxd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pxd_pkg::t_job i_push_job,
    output logic               o_not_full,
    output logic               o_not_empty,
    output pxd_pkg::t_job      o_head,
    input  wire logic          i_pop
);

    pxd_pkg::t_job r_mem [pxd_pkg::Q_DEPTH];
    logic          r_wptr, r_rptr;
    logic [1:0]    r_count;

    assign o_not_full  = (r_count != 2'(pxd_pkg::Q_DEPTH));
    assign o_not_empty = (r_count != 2'd0);
    assign o_head      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_not_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

/* design/pxd_back.sv */
`default_nettype none
module pxd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire pxd_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [31:0]        o_out_word,
    output logic               o_last_of_run
);

    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_last;
    logic        r_half;      // first word of a two-word job already issued
    logic        load;

    assign load          = !r_out_valid || i_out_ready;
    assign o_job_pop     = load && i_job_valid && (r_half || !i_job.two);
    assign o_out_valid   = r_out_valid;
    assign o_out_word    = r_out_word;
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_half      <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_job_valid;
            if (i_job_valid) begin
                r_half <= !r_half && i_job.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_job_valid) begin
            r_out_word <= r_half ? i_job.word1 : i_job.word0;
            r_out_last <= r_half || !i_job.two;
        end
    end

`ifndef NO_ASSERTIONS
    a_half_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (i_job_valid && i_job.two))
        else $error("second word pending without its job");
    a_half_shows_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (r_out_valid && !r_out_last))
        else $error("second word pending but first word not held");
`endif

endmodule
`default_nettype wire
